[sv/aabb_pkg.sv]
// Shared types and constants for the transformed bounding box pipeline.
`timescale 1ns / 1ps

package aabb_pkg;

    // Field and register widths
    localparam int COORD_W    = 32;
    localparam int EXT_W      = 31;
    localparam int FRAC_W     = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_ROWS   = 3;
    localparam int NUM_REGS   = 6;
    localparam int REG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = 2 * COORD_W;
    // Seven full-precision terms of at most 2^62 in magnitude fit in 68 bits
    localparam int SUM_W      = PROD_W + 4;
    localparam int NUM_STAGES = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [EXT_W-1:0]   extent_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic        [REG_W-1:0]   reg_t;
    typedef logic        [IDX_W-1:0]   reg_idx_t;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } reg_sel_t;

    // Identity matrix after reset
    localparam reg_t CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    // Per-stage load enables for one matrix row
    typedef struct packed {
        logic mul;
        logic part;
        logic total;
        logic bound;
        logic clamp;
    } row_adv_t;

endpackage

[sv/aabb_box_if.sv]
// Input channel carrying one box: corner position and dimensions.
`timescale 1ns / 1ps

interface aabb_box_if;
    import aabb_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t size_x;
    coord_t size_y;
    coord_t size_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, size_x, size_y, size_z,
        input  ready
    );

    modport sink (
        input  valid, pos_x, pos_y, pos_z, size_x, size_y, size_z,
        output ready
    );
endinterface

[sv/aabb_bound_if.sv]
// Output channel carrying one transformed box: minimum corner and extent.
`timescale 1ns / 1ps

interface aabb_bound_if;
    import aabb_pkg::*;

    logic    valid;
    logic    ready;
    coord_t  min_x;
    coord_t  min_y;
    coord_t  min_z;
    extent_t extent_x;
    extent_t extent_y;
    extent_t extent_z;

    modport source (
        output valid, min_x, min_y, min_z, extent_x, extent_y, extent_z,
        input  ready
    );

    modport sink (
        input  valid, min_x, min_y, min_z, extent_x, extent_y, extent_z,
        output ready
    );
endinterface

[sv/aabb_affine_transform_top.sv]
// Top level: affine transform of an axis-aligned box, pipelined six deep.
//
//   channel   direction  transaction               handshake
//   box       in         pos_x..z, size_x..z       box.valid / box.ready
//   bound     out        min_x..z, extent_x..z     bound.valid / bound.ready
//   cfg       in         cfg_addr, cfg_wdata       cfg_we (write only)
//
// One box per cycle unless bound.ready stalls; six register stages (multiply, two
// adder levels, bound add, floor/clamp, span/clamp). bound.valid is the last
// stage valid bit. Reset clears every stage valid bit and loads the identity
// matrix. A stall lets bubbles close up; a full stage holds until the next frees.
`timescale 1ns / 1ps

module aabb_affine_transform_top (
    input  logic                clk,
    input  logic                rst_n,
    aabb_box_if.sink            box,
    aabb_bound_if.source        bound,
    input  logic                cfg_we,
    input  aabb_pkg::reg_idx_t  cfg_addr,
    input  aabb_pkg::reg_t      cfg_wdata
);
    import aabb_pkg::*;

    reg_t                  matrix_reg [NUM_REGS];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_rdy;
    row_adv_t              adv;

    coord_t pos  [NUM_AXES];
    coord_t size [NUM_AXES];
    coord_t lo   [NUM_ROWS];
    coord_t hi   [NUM_ROWS];

    coord_t  min_reg    [NUM_ROWS];
    extent_t extent_reg [NUM_ROWS];
    extent_t extent_next[NUM_ROWS];
    logic signed [COORD_W:0] span [NUM_ROWS];

    // Write matrix registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                matrix_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            case (reg_sel_t'(cfg_addr))
                REG_ROW0_COLS01: matrix_reg[REG_ROW0_COLS01] <= cfg_wdata;
                REG_ROW0_COLS23: matrix_reg[REG_ROW0_COLS23] <= cfg_wdata;
                REG_ROW1_COLS01: matrix_reg[REG_ROW1_COLS01] <= cfg_wdata;
                REG_ROW1_COLS23: matrix_reg[REG_ROW1_COLS23] <= cfg_wdata;
                REG_ROW2_COLS01: matrix_reg[REG_ROW2_COLS01] <= cfg_wdata;
                REG_ROW2_COLS23: matrix_reg[REG_ROW2_COLS23] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage k may load when empty or when the stage after it advances
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || bound.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= box.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign box.ready = stage_rdy[0];

    // Load enables for the row stages
    always_comb
    begin
        adv.mul   = stage_rdy[0] && box.valid;
        adv.part  = stage_rdy[1] && valid_reg[0];
        adv.total = stage_rdy[2] && valid_reg[1];
        adv.bound = stage_rdy[3] && valid_reg[2];
        adv.clamp = stage_rdy[4] && valid_reg[3];
    end

    assign pos[0]  = box.pos_x;
    assign pos[1]  = box.pos_y;
    assign pos[2]  = box.pos_z;
    assign size[0] = box.size_x;
    assign size[1] = box.size_y;
    assign size[2] = box.size_z;

    // One datapath per matrix row
    for (genvar r = 0; r < NUM_ROWS; r++)
    begin : g_row
        coord_t m [NUM_AXES];

        assign m[0] = matrix_reg[2*r][COORD_W-1:0];
        assign m[1] = matrix_reg[2*r][REG_W-1:COORD_W];
        assign m[2] = matrix_reg[2*r+1][COORD_W-1:0];

        aabb_row u_row (
            .clk   (clk),
            .adv   (adv),
            .m     (m),
            .trans (matrix_reg[2*r+1][REG_W-1:COORD_W]),
            .pos   (pos),
            .size  (size),
            .lo    (lo[r]),
            .hi    (hi[r])
        );
    end

    // Span and its saturation
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            span[r] = {hi[r][COORD_W-1], hi[r]} - {lo[r][COORD_W-1], lo[r]};
            if (span[r][COORD_W:COORD_W-1] != 2'b00)
            begin
                extent_next[r] = {EXT_W{1'b1}};
            end
            else
            begin
                extent_next[r] = span[r][EXT_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (stage_rdy[NUM_STAGES-1] && valid_reg[NUM_STAGES-2])
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                min_reg[r]    <= lo[r];
                extent_reg[r] <= extent_next[r];
            end
        end
    end

    assign bound.valid    = valid_reg[NUM_STAGES-1];
    assign bound.min_x    = min_reg[0];
    assign bound.min_y    = min_reg[1];
    assign bound.min_z    = min_reg[2];
    assign bound.extent_x = extent_reg[0];
    assign bound.extent_y = extent_reg[1];
    assign bound.extent_z = extent_reg[2];

endmodule

[sv/aabb_row.sv]
// One matrix row: least and greatest transformed corner coordinate, five stages.
`timescale 1ns / 1ps

module aabb_row (
    input  logic              clk,
    input  aabb_pkg::row_adv_t adv,
    input  aabb_pkg::coord_t  m     [aabb_pkg::NUM_AXES],
    input  aabb_pkg::coord_t  trans,
    input  aabb_pkg::coord_t  pos   [aabb_pkg::NUM_AXES],
    input  aabb_pkg::coord_t  size  [aabb_pkg::NUM_AXES],
    output aabb_pkg::coord_t  lo,
    output aabb_pkg::coord_t  hi
);
    import aabb_pkg::*;

    // Floor shift by the fraction width and saturate to a coordinate
    function automatic coord_t clamp_q16(sum_t s);
        sum_t                     sh;
        logic [SUM_W-COORD_W:0]   upper;
        begin
            sh    = s >>> FRAC_W;
            upper = sh[SUM_W-1:COORD_W-1];
            if ((&upper) || (~|upper))
            begin
                clamp_q16 = sh[COORD_W-1:0];
            end
            else if (sh[SUM_W-1])
            begin
                clamp_q16 = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                clamp_q16 = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    endfunction

    prod_t  pos_prod [NUM_AXES];
    prod_t  size_prod[NUM_AXES];
    prod_t  pos_prod_reg [NUM_AXES];
    prod_t  size_prod_reg[NUM_AXES];
    coord_t trans_reg;

    sum_t   base_a_reg, base_b_reg;
    sum_t   neg_a_reg, neg_b_reg;
    sum_t   pls_a_reg, pls_b_reg;
    sum_t   base_reg, neg_reg, pls_reg;
    sum_t   lo_sum_reg, hi_sum_reg;
    coord_t lo_reg, hi_reg;

    sum_t   size_ext [NUM_AXES];
    sum_t   size_neg [NUM_AXES];
    sum_t   size_pos [NUM_AXES];

    // Full-precision products, one multiplier each
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pos_prod[i]  = m[i] * pos[i];
            size_prod[i] = m[i] * size[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                pos_prod_reg[i]  <= pos_prod[i];
                size_prod_reg[i] <= size_prod[i];
            end
            trans_reg <= trans;
        end
    end

    // Split each size term into its negative and positive share
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            size_ext[i] = sum_t'(size_prod_reg[i]);
            size_neg[i] = size_prod_reg[i][PROD_W-1] ? size_ext[i] : '0;
            size_pos[i] = size_prod_reg[i][PROD_W-1] ? '0 : size_ext[i];
        end
    end

    // Pairwise partial sums
    always_ff @(posedge clk)
    begin
        if (adv.part)
        begin
            base_a_reg <= sum_t'(pos_prod_reg[0]) + sum_t'(pos_prod_reg[1]);
            base_b_reg <= sum_t'(pos_prod_reg[2]) + (sum_t'(trans_reg) <<< FRAC_W);
            neg_a_reg  <= size_neg[0] + size_neg[1];
            neg_b_reg  <= size_neg[2];
            pls_a_reg  <= size_pos[0] + size_pos[1];
            pls_b_reg  <= size_pos[2];
        end
    end

    // Box origin term and the extreme size offsets
    always_ff @(posedge clk)
    begin
        if (adv.total)
        begin
            base_reg <= base_a_reg + base_b_reg;
            neg_reg  <= neg_a_reg + neg_b_reg;
            pls_reg  <= pls_a_reg + pls_b_reg;
        end
    end

    // Least and greatest corner sums; shift and clamp are monotonic
    always_ff @(posedge clk)
    begin
        if (adv.bound)
        begin
            lo_sum_reg <= base_reg + neg_reg;
            hi_sum_reg <= base_reg + pls_reg;
        end
    end

    // Round toward minus infinity and saturate
    always_ff @(posedge clk)
    begin
        if (adv.clamp)
        begin
            lo_reg <= clamp_q16(lo_sum_reg);
            hi_reg <= clamp_q16(hi_sum_reg);
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule
